// ----- rtl/mavf_pkg.sv -----
// ----------------------------------------------------------------------------
// mavf_pkg
// shared constants for the four-channel moving-average framer
// ----------------------------------------------------------------------------
package mavf_pkg;

    localparam int CHAN_W    = 16;
    localparam int NUM_CHAN  = 4;
    localparam int CH_IDX_W  = 2;
    localparam int RING_W    = CHAN_W * NUM_CHAN;
    localparam int BYTE_W    = 8;
    localparam int FRAME_LEN = 10;
    localparam int BYTE_IDX_W = 4;

    localparam logic [BYTE_W-1:0]     FRAME_HEADER = 8'h5A;
    localparam logic [BYTE_IDX_W-1:0] BYTE_FIRST   = 4'd0;
    localparam logic [BYTE_IDX_W-1:0] BYTE_LAST    = 4'(FRAME_LEN - 1);

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [BYTE_W-1:0] t_byte;

endpackage

// ----- rtl/four_channel_moving_average_framer.sv -----
// ----------------------------------------------------------------------------
// four_channel_moving_average_framer
// boxcar average of four 16-bit channels over a ring, sent as a 10-byte frame
// ----------------------------------------------------------------------------
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------------------------
//  in      | i_valid | o_stall | i_x_high_time i_x_period i_y_high_time i_y_period
//  out     | o_valid | i_stall | o_frame_byte o_last_byte
//
//  for each measurement a single accumulator adder walks every ring entry and
//  channel, one channel a cycle, then ten frame bytes leave one a cycle while
//  the output is not stalled.
//  reset clears the per-entry valid bits, so the ring reads as zero at once.
//  output stalls only hold the frame phase; o_stall stays high until the
//  checksum byte is loaded into the output register.
// ----------------------------------------------------------------------------
module four_channel_moving_average_framer #(
    parameter int WINDOW    = 16,
    parameter int AVG_SHIFT = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  mavf_pkg::t_chan       i_x_high_time,
    input  mavf_pkg::t_chan       i_x_period,
    input  mavf_pkg::t_chan       i_y_high_time,
    input  mavf_pkg::t_chan       i_y_period,
    output logic                  o_valid,
    input  logic                  i_stall,
    output mavf_pkg::t_byte       o_frame_byte,
    output logic                  o_last_byte
);
    import mavf_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = CHAN_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_ENT = IDX_W'(WINDOW - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SUM   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_slot;
    logic [IDX_W-1:0]      r_ent;
    logic [CH_IDX_W-1:0]   r_ch;
    logic [WINDOW-1:0]     r_vld;
    logic [RING_W-1:0]     r_ring [WINDOW];
    logic [RING_W-1:0]     r_rd_data;
    logic                  r_rd_vld;
    logic [CH_IDX_W-1:0]   r_rd_ch;
    logic                  r_rd_go;
    logic [SUM_W-1:0]      r_acc [NUM_CHAN];
    logic [BYTE_IDX_W-1:0] r_byte;
    t_byte                 r_chk;
    logic                  r_out_valid;
    t_byte                 r_out_byte;
    logic                  r_out_last;

    logic                  in_take;
    logic                  issue_last;
    logic                  out_free;
    logic                  out_load;
    t_chan                 rd_chan;
    logic [SUM_W-1:0]      acc_sum;
    logic [BYTE_IDX_W-1:0] avg_idx;
    logic [SUM_W-1:0]      avg_full;
    t_chan                 avg_sel;
    t_byte                 avg_byte;
    t_byte                 n_out_byte;

    assign in_take    = i_valid && (r_state == S_IDLE);
    assign o_stall    = (r_state != S_IDLE);
    assign issue_last = (r_ent == LAST_ENT) && (r_ch == CH_IDX_W'(NUM_CHAN - 1));
    assign out_free   = !r_out_valid || !i_stall;
    assign out_load   = (r_state == S_EMIT) && out_free;

    // shared adder: one channel of one ring entry per cycle
    assign rd_chan = r_rd_vld ? r_rd_data[r_rd_ch*CHAN_W +: CHAN_W] : '0;
    assign acc_sum = r_acc[r_rd_ch] + SUM_W'(rd_chan);

    // frame bytes 1..8 are the averages, low byte first
    assign avg_idx  = r_byte - 4'd1;
    assign avg_full = r_acc[avg_idx[2:1]] >> AVG_SHIFT;
    assign avg_sel  = avg_full[CHAN_W-1:0];
    assign avg_byte = avg_idx[0] ? avg_sel[15:8] : avg_sel[7:0];

    always_comb begin
        if (r_byte == BYTE_FIRST) begin
            n_out_byte = FRAME_HEADER;
        end else if (r_byte == BYTE_LAST) begin
            n_out_byte = r_chk;
        end else begin
            n_out_byte = avg_byte;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_take) n_state = S_SUM;
            S_SUM:   if (issue_last) n_state = S_DRAIN;
            S_DRAIN: n_state = S_EMIT;
            S_EMIT:  if (out_load && (r_byte == BYTE_LAST)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_ent       <= '0;
            r_ch        <= '0;
            r_vld       <= '0;
            r_rd_go     <= 1'b0;
            r_byte      <= BYTE_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_go <= (r_state == S_SUM);
            if (in_take) begin
                r_vld[r_slot] <= 1'b1;
                r_slot        <= (r_slot == LAST_ENT) ? '0 : r_slot + 1'b1;
                r_ent         <= '0;
                r_ch          <= '0;
                r_byte        <= BYTE_FIRST;
            end else if (r_state == S_SUM) begin
                r_ch <= r_ch + 1'b1;
                if (r_ch == CH_IDX_W'(NUM_CHAN - 1)) begin
                    r_ent <= r_ent + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_byte      <= r_byte + 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ring memory and its registered read port
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ring[r_slot] <= {i_y_period, i_y_high_time, i_x_period, i_x_high_time};
        end
        r_rd_data <= r_ring[r_ent];
        r_rd_vld  <= r_vld[r_ent];
        r_rd_ch   <= r_ch;
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_acc[c] <= '0;
            end
            r_chk <= FRAME_HEADER;
        end else begin
            if (r_rd_go) begin
                r_acc[r_rd_ch] <= acc_sum;
            end
            if (out_load && (r_byte != BYTE_FIRST) && (r_byte != BYTE_LAST)) begin
                r_chk <= r_chk + avg_byte;
            end
        end
        if (out_load) begin
            r_out_byte <= n_out_byte;
            r_out_last <= (r_byte == BYTE_LAST);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

endmodule

// ----- rtl/mavf_checker.sv -----
// ----------------------------------------------------------------------------
// mavf_checker
// port-level checks for the moving-average framer, bound to the top level
// ----------------------------------------------------------------------------
module mavf_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            o_stall,
    input  logic            o_valid,
    input  logic            i_stall,
    input  mavf_pkg::t_byte o_frame_byte,
    input  logic            o_last_byte
);
    import mavf_pkg::*;

    // a stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_byte) && $stable(o_last_byte))
        else $error("output payload changed under stall");

    // an accepted measurement makes the block busy
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not blocked after transaction");

    // a frame in flight keeps the input blocked until its checksum is loaded
    a_busy_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_byte |-> o_stall)
        else $error("input open before frame end");

    // every frame opens with the header byte
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_frame_byte == FRAME_HEADER) && !o_last_byte)
        else $error("frame does not start with header");

endmodule

bind four_channel_moving_average_framer mavf_checker u_mavf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_frame_byte (o_frame_byte),
    .o_last_byte  (o_last_byte)
);
